// ===== rtl/core/tuple_intern_table_unit_defines.svh =====
// Assertion macros for the tuple intern table unit.
`ifndef TUPLE_INTERN_TABLE_UNIT_DEFINES_SVH
`define TUPLE_INTERN_TABLE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TIT_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define TIT_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) (cond)) else $error(msg);
`else
`define TIT_ASSERT(lbl, cond, msg)
`define TIT_ASSERT_ALWAYS(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/tit_pkg.sv =====
// Shared widths and status codes of the tuple intern table.
`default_nettype none
package tit_pkg;

  localparam int OP_W        = 1;
  localparam int ARITY_W     = 4;
  localparam int ATOM_W      = 16;
  localparam int ATOM_FIELDS = 8;
  localparam int VAR_W       = 9;
  localparam int STATUS_W    = 3;

  localparam logic [OP_W-1:0] OP_REGISTER = 1'b0;
  localparam logic [OP_W-1:0] OP_LOOKUP   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_ARITY = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd4;

endpackage
`default_nettype wire

// ===== rtl/core/tit_if.sv =====
// Request and response channel interfaces of the tuple intern table.
`default_nettype none
interface tit_in_if;
  logic                        valid;
  logic                        ready;
  logic [tit_pkg::OP_W-1:0]    op;
  logic [tit_pkg::ARITY_W-1:0] arity;
  logic [tit_pkg::ATOM_W-1:0]  atom_0;
  logic [tit_pkg::ATOM_W-1:0]  atom_1;
  logic [tit_pkg::ATOM_W-1:0]  atom_2;
  logic [tit_pkg::ATOM_W-1:0]  atom_3;
  logic [tit_pkg::ATOM_W-1:0]  atom_4;
  logic [tit_pkg::ATOM_W-1:0]  atom_5;
  logic [tit_pkg::ATOM_W-1:0]  atom_6;
  logic [tit_pkg::ATOM_W-1:0]  atom_7;

  modport source (output valid, op, arity, atom_0, atom_1, atom_2, atom_3,
                  atom_4, atom_5, atom_6, atom_7, input ready);
  modport sink   (input valid, op, arity, atom_0, atom_1, atom_2, atom_3,
                  atom_4, atom_5, atom_6, atom_7, output ready);
endinterface

interface tit_out_if;
  logic                         valid;
  logic                         ready;
  logic [tit_pkg::VAR_W-1:0]    var_number;
  logic [tit_pkg::STATUS_W-1:0] status;

  modport source (output valid, var_number, status, input ready);
  modport sink   (input valid, var_number, status, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tit_match.sv =====
// Entry compare unit: arity and zero-padded atom row against the search key.
`default_nettype none
module tit_match #(
  parameter int MAX_ARITY = 8,
  parameter int ATOM_BITS = 16
) (
  input  wire logic [tit_pkg::ARITY_W-1:0]            key_arity,
  input  wire logic [MAX_ARITY-1:0][ATOM_BITS-1:0]    key_atoms,
  input  wire logic [tit_pkg::ARITY_W+MAX_ARITY*ATOM_BITS-1:0] entry,
  output logic                                        match
);
  import tit_pkg::*;

  localparam int DATA_W = MAX_ARITY * ATOM_BITS;

  logic [ARITY_W-1:0] ent_arity;
  logic [DATA_W-1:0]  ent_atoms;
  logic               arity_eq;
  logic [MAX_ARITY-1:0] atom_eq;

  assign ent_arity = entry[ARITY_W+DATA_W-1 -: ARITY_W];
  assign ent_atoms = entry[DATA_W-1:0];
  assign arity_eq  = (ent_arity == key_arity);

  always_comb begin
    for (int k = 0; k < MAX_ARITY; k++) begin
      atom_eq[k] = (ent_atoms[k*ATOM_BITS +: ATOM_BITS] == key_atoms[k]);
    end
  end

  assign match = arity_eq && (&atom_eq);

endmodule
`default_nettype wire

// ===== rtl/core/tuple_intern_table_unit.sv =====
// Path: bad arity goes to S_EMIT; an empty table goes through S_MISS to S_EMIT; otherwise
// S_SEARCH scans stored entries up to a hit (then S_EMIT) or the last one (then S_MISS).
// One entry is read from the table memory and compared per cycle, in insertion order.
// Throughput: one beat at a time; the next beat is taken once the sequencer is idle.
// A finished result waits in the output register while the next beat is taken.
// Reset (rst, synchronous) empties the table by clearing the entry count; no clearing pass.
`default_nettype none
`include "tuple_intern_table_unit_defines.svh"
module tuple_intern_table_unit #(
  parameter int TABLE_DEPTH = 256,
  parameter int MAX_ARITY   = 8,
  parameter int ATOM_BITS   = 16
) (
  input  wire logic  clk,
  input  wire logic  rst,
  tit_in_if.sink     req,
  tit_out_if.source  rsp
);
  import tit_pkg::*;

  localparam int IDX_W   = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W  = MAX_ARITY * ATOM_BITS;
  localparam int ENTRY_W = ARITY_W + DATA_W;
  localparam int VW      = (CNT_W > VAR_W) ? CNT_W : VAR_W;

  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_MISS, S_EMIT} state_t;

  state_t                            state;
  logic [OP_W-1:0]                   op_q;
  logic [ARITY_W-1:0]                key_arity;
  logic [MAX_ARITY-1:0][ATOM_BITS-1:0] key_atoms;
  logic [CNT_W-1:0]                  count;
  logic [CNT_W-1:0]                  scan;
  logic                              chk_valid;
  logic [IDX_W-1:0]                  chk_idx;
  logic [VAR_W-1:0]                  res_var;
  logic [STATUS_W-1:0]               res_status;
  logic                              out_valid;
  logic [VAR_W-1:0]                  out_var;
  logic [STATUS_W-1:0]               out_status;

  logic [ENTRY_W-1:0]                mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]                rd_data;
  logic                              wr_en;

  logic [ATOM_FIELDS-1:0][ATOM_W-1:0]  in_atoms;
  logic [MAX_ARITY-1:0][ATOM_BITS-1:0] in_key_atoms;
  logic                              in_bad;
  logic                              match;
  logic                              chk_last;
  logic                              table_full;
  logic [VW-1:0]                     hit_var_w;
  logic [VW-1:0]                     new_var_w;

  assign in_atoms[0] = req.atom_0;
  assign in_atoms[1] = req.atom_1;
  assign in_atoms[2] = req.atom_2;
  assign in_atoms[3] = req.atom_3;
  assign in_atoms[4] = req.atom_4;
  assign in_atoms[5] = req.atom_5;
  assign in_atoms[6] = req.atom_6;
  assign in_atoms[7] = req.atom_7;

  always_comb begin
    for (int k = 0; k < MAX_ARITY; k++) begin
      in_key_atoms[k] = (ARITY_W'(k) < req.arity) ? ATOM_BITS'(in_atoms[k]) : '0;
    end
  end

  assign in_bad     = (req.arity == '0) || (req.arity > ARITY_W'(MAX_ARITY));
  assign table_full = (count >= CNT_W'(TABLE_DEPTH));
  assign chk_last   = ((CNT_W'(chk_idx) + CNT_W'(1)) == count);
  assign hit_var_w  = VW'(chk_idx) + VW'(1);
  assign new_var_w  = VW'(count) + VW'(1);
  assign wr_en      = (state == S_MISS) && (op_q == OP_REGISTER) && !table_full;

  assign req.ready      = (state == S_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.var_number = out_var;
  assign rsp.status     = out_status;

  tit_match #(
    .MAX_ARITY (MAX_ARITY),
    .ATOM_BITS (ATOM_BITS)
  ) u_match (
    .key_arity (key_arity),
    .key_atoms (key_atoms),
    .entry     (rd_data),
    .match     (match)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IDX_W-1:0]] <= {key_arity, key_atoms};
    end
    rd_data <= mem[scan[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          chk_valid <= 1'b0;
          scan      <= '0;
          if (req.valid) begin
            op_q      <= req.op;
            key_arity <= req.arity;
            key_atoms <= in_key_atoms;
            if (in_bad) begin
              res_var    <= '0;
              res_status <= ST_BAD_ARITY;
              state      <= S_EMIT;
            end else if (count == '0) begin
              state <= S_MISS;
            end else begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          chk_valid <= (scan < count);
          chk_idx   <= scan[IDX_W-1:0];
          if (scan < count) begin
            scan <= scan + CNT_W'(1);
          end
          if (chk_valid && match) begin
            res_var    <= hit_var_w[VAR_W-1:0];
            res_status <= ST_FOUND;
            state      <= S_EMIT;
          end else if (chk_valid && chk_last) begin
            state <= S_MISS;
          end
        end
        S_MISS: begin
          chk_valid <= 1'b0;
          res_var   <= '0;
          if (op_q == OP_LOOKUP) begin
            res_status <= ST_MISSING;
          end else if (table_full) begin
            res_status <= ST_FULL;
          end else begin
            res_var    <= new_var_w[VAR_W-1:0];
            res_status <= ST_ADDED;
            count      <= count + CNT_W'(1);
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_var    <= res_var;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `TIT_ASSERT(a_count_bound, count <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
  `TIT_ASSERT(a_write_grows, wr_en |=> count == $past(count) + CNT_W'(1), "write without count step")
  `TIT_ASSERT(a_search_nonempty, (state == S_SEARCH) |-> (count != '0), "search on empty table")
  `TIT_ASSERT(a_scan_bound, (state == S_SEARCH) |-> (scan <= count), "scan past stored entries")

endmodule
`default_nettype wire
